[hw/rtl/pbsc_pkg.sv]
// ---------------------------------------------------------------------------
// Plane/box section centroid package
// Shared types, register indexes and constants for the section centroid block.
// ---------------------------------------------------------------------------
package pbsc_pkg;

  localparam logic signed [31:0] NORM_ONE = 32'sh4000_0000;
  localparam logic [30:0] SIZE_RESET = 31'd16777216;
  localparam logic [15:0] TOL_RESET = 16'd1;
  localparam logic [30:0] FLOOR_RESET = 31'd1;
  localparam logic [5:0] EDGE_QBITS = 6'd33;
  localparam logic [5:0] MEAN_QBITS = 6'd37;

  typedef enum logic [2:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_TOL    = 3'd3,
    REG_FLOOR  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [2:0][30:0] size;
    logic [15:0]      tol;
    logic [30:0]      flr;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] n;
    logic [2:0][31:0] tip;
    logic [2:0]       dneg;
    logic [2:0][30:0] dmag;
  } item_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [3:0]  kept;
    logic        fallback;
  } result_t;

endpackage

[hw/rtl/pbsc_front.sv]
// ---------------------------------------------------------------------------
// Front stage
// Accepts a plane, clamps the normal and picks the divisor of each axis.
// ---------------------------------------------------------------------------
module pbsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         normal_x,
  input  logic [31:0]         normal_y,
  input  logic [31:0]         normal_z,
  input  logic [31:0]         tip_x,
  input  logic [31:0]         tip_y,
  input  logic [31:0]         tip_z,
  input  pbsc_pkg::cfg_t      cfg,
  output pbsc_pkg::item_t     item,
  output logic                q_push,
  input  logic                q_full
);

  logic                 valid;
  pbsc_pkg::item_t      item_next;
  logic signed [31:0]   raw [3];
  logic signed [31:0]   nc [3];
  logic [31:0]          nabs [3];
  logic [30:0]          flr;

  assign raw[0] = $signed(normal_x);
  assign raw[1] = $signed(normal_y);
  assign raw[2] = $signed(normal_z);

  always_comb begin
    flr = (cfg.flr == 31'd0) ? 31'd1 : cfg.flr;
    item_next.tip[0] = tip_x;
    item_next.tip[1] = tip_y;
    item_next.tip[2] = tip_z;
    for (int j = 0; j < 3; j++) begin
      if (raw[j] > pbsc_pkg::NORM_ONE) begin
        nc[j] = pbsc_pkg::NORM_ONE;
      end else if (raw[j] < -pbsc_pkg::NORM_ONE) begin
        nc[j] = -pbsc_pkg::NORM_ONE;
      end else begin
        nc[j] = raw[j];
      end
      nabs[j] = nc[j][31] ? (32'd0 - nc[j]) : nc[j];
      item_next.n[j] = nc[j];
      if (nabs[j][30:0] < flr) begin
        item_next.dneg[j] = 1'b0;
        item_next.dmag[j] = flr;
      end else begin
        item_next.dneg[j] = nc[j][31];
        item_next.dmag[j] = nabs[j][30:0];
      end
    end
  end

  assign full = valid & q_full;
  assign q_push = valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push && !full) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      item <= item_next;
    end
  end

endmodule

[hw/rtl/pbsc_item_q.sv]
// ---------------------------------------------------------------------------
// Item queue
// Two-entry queue that carries classified planes from the front to the back.
// ---------------------------------------------------------------------------
module pbsc_item_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pbsc_pkg::item_t  wr_item,
  output logic             q_full,
  output logic             rd_valid,
  input  logic             rd,
  output pbsc_pkg::item_t  rd_item
);

  pbsc_pkg::item_t  entry [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;

  assign q_full = count[1];
  assign rd_valid = (count != 2'd0);
  assign rd_item = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wp] <= wr_item;
    end
  end

endmodule

[hw/rtl/pbsc_back.sv]
// ---------------------------------------------------------------------------
// Back stage
// Forms the edge numerators, divides them one at a time on a shared
// restoring divider, accumulates the kept points and takes their mean.
// ---------------------------------------------------------------------------
module pbsc_back (
  input  logic               clk,
  input  logic               rst,
  input  pbsc_pkg::cfg_t     cfg,
  input  logic               item_valid,
  input  pbsc_pkg::item_t    item,
  output logic               item_pop,
  output logic               empty,
  input  logic               pop,
  output pbsc_pkg::result_t  result
);

  typedef enum logic [9:0] {
    B_IDLE = 10'b00_0000_0001,
    B_MUL  = 10'b00_0000_0010,
    B_NUM  = 10'b00_0000_0100,
    B_CHK  = 10'b00_0000_1000,
    B_DIV  = 10'b00_0001_0000,
    B_KEEP = 10'b00_0010_0000,
    B_MSET = 10'b00_0100_0000,
    B_MDIV = 10'b00_1000_0000,
    B_MSAV = 10'b01_0000_0000,
    B_OUT  = 10'b10_0000_0000
  } state_t;

  state_t              state;
  logic [2:0]          mi;
  logic [1:0]          ax;
  logic [1:0]          kk;
  logic [1:0]          mj;
  logic signed [63:0]  prod_t [3];
  logic signed [63:0]  prod_d [3];
  logic [63:0]         nmag;
  logic                nneg;
  logic [30:0]         rem;
  logic [63:0]         dvd;
  logic [36:0]         quo;
  logic [5:0]          dcnt;
  logic [30:0]         dv;
  logic signed [37:0]  sum [3];
  logic [3:0]          kept;
  logic [31:0]         cent [3];

  pbsc_pkg::result_t   ob [2];
  logic                owp;
  logic                orp;
  logic [1:0]          ocount;
  logic                opush;

  logic signed [31:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [64:0]  mul_p;
  logic signed [63:0]  pa;
  logic signed [63:0]  pb;
  logic signed [63:0]  pc;
  logic signed [65:0]  num;
  logic [65:0]         num_abs;
  logic [1:0]          bax;
  logic [1:0]          cax;
  logic [30:0]         dmag_sel;
  logic                dneg_sel;
  logic [31:0]         r2;
  logic [31:0]         rdiff;
  logic                ge;
  logic [32:0]         q;
  logic                qneg;
  logic [32:0]         lim;
  logic                keep;
  logic signed [37:0]  v;
  logic signed [37:0]  term [3];
  logic signed [37:0]  ssel;
  logic [37:0]         sabs;
  logic signed [37:0]  mres;
  logic [31:0]         msat;
  logic                last_edge;

  assign mul_a = $signed(item.n[mi[2:1]]);
  assign mul_b = $signed({item.tip[mi[2:1]][31], item.tip[mi[2:1]]})
               - $signed({2'b00, (mi[0] ? cfg.size[mi[2:1]] : 31'd0)});
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (ax)
      2'd1: begin
        bax = 2'd2;
        cax = 2'd0;
      end
      2'd2: begin
        bax = 2'd0;
        cax = 2'd1;
      end
      default: begin
        bax = 2'd1;
        cax = 2'd2;
      end
    endcase
    pa = prod_t[ax];
    pb = kk[0] ? prod_d[bax] : prod_t[bax];
    pc = kk[1] ? prod_d[cax] : prod_t[cax];
    num = 66'(pa) + 66'(pb) + 66'(pc);
    num_abs = num[65] ? (66'd0 - num) : num;
    dmag_sel = item.dmag[ax];
    dneg_sel = item.dneg[ax];
    last_edge = (kk == 2'd3) && (ax == 2'd2);
  end

  always_comb begin
    r2 = {1'b0, rem} << 1 | {31'd0, dvd[63]};
    rdiff = r2 - {1'b0, dv};
    ge = (r2 >= {1'b0, dv});
  end

  always_comb begin
    q = quo[32:0];
    qneg = (nneg != dneg_sel) && (q != 33'd0);
    lim = qneg ? {17'd0, cfg.tol} : ({2'b00, cfg.size[ax]} + {17'd0, cfg.tol});
    keep = (q <= lim);
    v = qneg ? -$signed({5'd0, q}) : $signed({5'd0, q});
    for (int j = 0; j < 3; j++) begin
      if (2'(j) == ax) begin
        term[j] = v;
      end else if (2'(j) == bax) begin
        term[j] = kk[0] ? $signed({7'd0, cfg.size[j]}) : 38'sd0;
      end else begin
        term[j] = kk[1] ? $signed({7'd0, cfg.size[j]}) : 38'sd0;
      end
    end
  end

  always_comb begin
    ssel = sum[mj];
    sabs = ssel[37] ? (38'd0 - ssel) : ssel;
    mres = nneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (mres > 38'sh0_7FFF_FFFF) begin
      msat = 32'h7FFF_FFFF;
    end else if (mres < -38'sh0_8000_0000) begin
      msat = 32'h8000_0000;
    end else begin
      msat = mres[31:0];
    end
  end

  assign opush = (state == B_OUT) && !ocount[1];
  assign item_pop = opush;
  assign empty = (ocount == 2'd0);
  assign result = ob[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (item_valid) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          if (mi == 3'd5) begin
            state <= B_NUM;
          end
        end
        B_NUM: state <= B_CHK;
        B_CHK: begin
          if (num_abs[63:33] >= dmag_sel) begin
            state <= last_edge ? B_MSET : B_NUM;
          end else begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (dcnt == 6'd1) begin
            state <= B_KEEP;
          end
        end
        B_KEEP: state <= last_edge ? B_MSET : B_NUM;
        B_MSET: state <= (kept == 4'd0) ? B_OUT : B_MDIV;
        B_MDIV: begin
          if (dcnt == 6'd1) begin
            state <= B_MSAV;
          end
        end
        B_MSAV: state <= (mj == 2'd2) ? B_OUT : B_MSET;
        B_OUT: begin
          if (opush) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        mi <= 3'd0;
        ax <= 2'd0;
        kk <= 2'd0;
        mj <= 2'd0;
        kept <= 4'd0;
        for (int j = 0; j < 3; j++) begin
          sum[j] <= 38'sd0;
        end
      end
      B_MUL: begin
        if (mi[0]) begin
          prod_d[mi[2:1]] <= mul_p[63:0];
        end else begin
          prod_t[mi[2:1]] <= mul_p[63:0];
        end
        mi <= mi + 3'd1;
      end
      B_NUM: begin
        nmag <= num_abs[63:0];
        nneg <= num[65];
      end
      B_CHK: begin
        rem <= nmag[63:33];
        dvd <= {nmag[32:0], 31'd0};
        quo <= 37'd0;
        dcnt <= pbsc_pkg::EDGE_QBITS;
        dv <= dmag_sel;
        if (nmag[63:33] >= dmag_sel) begin
          kk <= kk + 2'd1;
          if (kk == 2'd3) begin
            ax <= ax + 2'd1;
          end
        end
      end
      B_DIV, B_MDIV: begin
        rem <= ge ? rdiff[30:0] : r2[30:0];
        dvd <= {dvd[62:0], 1'b0};
        quo <= {quo[35:0], ge};
        dcnt <= dcnt - 6'd1;
      end
      B_KEEP: begin
        if (keep) begin
          for (int j = 0; j < 3; j++) begin
            sum[j] <= sum[j] + term[j];
          end
          kept <= kept + 4'd1;
        end
        kk <= kk + 2'd1;
        if (kk == 2'd3) begin
          ax <= ax + 2'd1;
        end
      end
      B_MSET: begin
        rem <= 31'd0;
        dvd <= {sabs[36:0], 27'd0};
        quo <= 37'd0;
        dcnt <= pbsc_pkg::MEAN_QBITS;
        dv <= {27'd0, kept};
        nneg <= ssel[37];
        if (kept == 4'd0) begin
          for (int j = 0; j < 3; j++) begin
            cent[j] <= item.tip[j];
          end
        end
      end
      B_MSAV: begin
        cent[mj] <= msat;
        mj <= mj + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (opush) begin
        owp <= ~owp;
      end
      if (pop && !empty) begin
        orp <= ~orp;
      end
      ocount <= ocount + {1'b0, opush} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      ob[owp] <= '{cx: cent[0], cy: cent[1], cz: cent[2], kept: kept,
                   fallback: (kept == 4'd0)};
    end
  end

endmodule

[hw/rtl/plane_box_section_centroid.sv]
// ---------------------------------------------------------------------------
// Plane/box section centroid
// Cuts a plane with every edge of a configured box and returns the
// mean of the edge points that fall inside it, or the plane tip when none do.
// ---------------------------------------------------------------------------
// The back stage forms six products per plane, then takes each edge through a
// numerator and an early-reject check, and through a division and a keep step
// when not rejected early; when any point is kept, the three means follow,
// each set up, divided and saved. The shared divider retires one quotient bit
// per cycle. The front stage and a two-entry queue accept the next plane while
// one is in work, and a two-entry result queue holds finished results.
module plane_box_section_centroid (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  input  logic [31:0] tip_x,
  input  logic [31:0] tip_y,
  input  logic [31:0] tip_z,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] centroid_x,
  output logic [31:0] centroid_y,
  output logic [31:0] centroid_z,
  output logic [3:0]  kept_count,
  output logic        used_fallback,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pbsc_pkg::cfg_t     cfg;
  pbsc_pkg::item_t    f_item;
  pbsc_pkg::item_t    b_item;
  pbsc_pkg::result_t  res;
  logic               q_push;
  logic               q_full;
  logic               b_valid;
  logic               b_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size[0] <= pbsc_pkg::SIZE_RESET;
      cfg.size[1] <= pbsc_pkg::SIZE_RESET;
      cfg.size[2] <= pbsc_pkg::SIZE_RESET;
      cfg.tol <= pbsc_pkg::TOL_RESET;
      cfg.flr <= pbsc_pkg::FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbsc_pkg::REG_SIZE_X: cfg.size[0] <= cfg_data[30:0];
        pbsc_pkg::REG_SIZE_Y: cfg.size[1] <= cfg_data[30:0];
        pbsc_pkg::REG_SIZE_Z: cfg.size[2] <= cfg_data[30:0];
        pbsc_pkg::REG_TOL:    cfg.tol <= cfg_data[15:0];
        pbsc_pkg::REG_FLOOR:  cfg.flr <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  pbsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .tip_x    (tip_x),
    .tip_y    (tip_y),
    .tip_z    (tip_z),
    .cfg      (cfg),
    .item     (f_item),
    .q_push   (q_push),
    .q_full   (q_full)
  );

  pbsc_item_q u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_item  (f_item),
    .q_full   (q_full),
    .rd_valid (b_valid),
    .rd       (b_pop),
    .rd_item  (b_item)
  );

  pbsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (b_valid),
    .item       (b_item),
    .item_pop   (b_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (res)
  );

  assign centroid_x = res.cx;
  assign centroid_y = res.cy;
  assign centroid_z = res.cz;
  assign kept_count = res.kept;
  assign used_fallback = res.fallback;

`ifndef NO_ASSERTIONS
  a_fallback_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && used_fallback) |-> (kept_count == 4'd0))
    else $error("Fallback result carries a nonzero count.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && !used_fallback) |-> (kept_count != 4'd0 && kept_count <= 4'd12))
    else $error("Kept count out of range for a normal result.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("Result queue not empty after reset.");

  a_pop_backlog: assert property (@(posedge clk) disable iff (rst)
    (b_pop && !b_valid) |-> 1'b0)
    else $error("Back stage took an item from an empty queue.");
`endif

endmodule
